/* rtl/core/stbs_pkg.sv */
// Shared types, character codes and token kind codes for the SQL token
// boundary scanner. No dependencies.
`default_nettype none

package stbs_pkg;

  // Input transaction: one text byte or the end-of-text mark.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_mark;
  } in_item_t;

  // Output transaction: one token.
  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        overflow_seen;
    logic        run_last;
  } out_item_t;

  localparam int unsigned MaxResults = 3;

  // All tokens produced by one input byte, oldest in item[0].
  typedef struct packed {
    logic [1:0]                  count;
    out_item_t [MaxResults-1:0]  item;
  } group_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_MINUS,
    MODE_DOT,
    MODE_STRING,
    MODE_GT,
    MODE_LT
  } mode_e;

  localparam logic [3:0] KIND_WORD      = 4'd0;
  localparam logic [3:0] KIND_INTEGER   = 4'd1;
  localparam logic [3:0] KIND_DECIMAL   = 4'd2;
  localparam logic [3:0] KIND_STRING    = 4'd3;
  localparam logic [3:0] KIND_STAR      = 4'd4;
  localparam logic [3:0] KIND_COMMA     = 4'd5;
  localparam logic [3:0] KIND_LPAREN    = 4'd6;
  localparam logic [3:0] KIND_RPAREN    = 4'd7;
  localparam logic [3:0] KIND_SEMICOLON = 4'd8;
  localparam logic [3:0] KIND_EQUALS    = 4'd9;
  localparam logic [3:0] KIND_GT        = 4'd10;
  localparam logic [3:0] KIND_GE        = 4'd11;
  localparam logic [3:0] KIND_LT        = 4'd12;
  localparam logic [3:0] KIND_LE        = 4'd13;
  localparam logic [3:0] KIND_INVALID   = 4'd14;
  localparam logic [3:0] KIND_END       = 4'd15;

  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_QUOTE   = 8'h27;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  // space, TAB, LF, VT, FF, CR
  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

endpackage

`default_nettype wire

/* rtl/core/sql_token_boundary_scanner.sv */
// SQL token boundary scanner, one text byte per transaction.
// Flow: with the output stage free, a byte's tokens pass through the group queue
// and then the output register before they show on the result ports to be popped.
// Throughput: one byte per cycle while the queue is not full; a byte that closes k
// tokens holds the output register for k pops, and the two-group queue lets the scanner run ahead meanwhile.
// Reset (async, active low) clears scan state, position, queue and output stage.
`default_nettype none

module sql_token_boundary_scanner #(
  parameter int unsigned POSITION_WIDTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire stbs_pkg::in_item_t in_item_i,
  output logic                    empty,
  input  wire logic               pop,
  output stbs_pkg::out_item_t     out_item_o
);

  logic             accept;
  logic             grp_valid;
  stbs_pkg::group_t grp;
  logic             q_valid;
  stbs_pkg::group_t q_data;
  logic             q_take;

  assign accept = push && !full;

  stbs_front #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_item_i  (in_item_i),
    .grp_valid_o(grp_valid),
    .grp_o      (grp)
  );

  stbs_group_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (grp_valid),
    .wdata_i(grp),
    .full_o (full),
    .valid_o(q_valid),
    .pop_i  (q_take),
    .rdata_o(q_data)
  );

  stbs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .grp_valid_i(q_valid),
    .grp_i      (q_data),
    .grp_take_o (q_take),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

/* rtl/core/stbs_front.sv */
// Scanner front end: tracks the lexer mode and builds the group of tokens
// that each accepted byte produces. Depends on stbs_pkg.
`default_nettype none

module stbs_front #(
  parameter int unsigned POSITION_WIDTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire stbs_pkg::in_item_t in_item_i,
  output logic                   grp_valid_o,
  output stbs_pkg::group_t       grp_o
);

  localparam int unsigned PW = POSITION_WIDTH;
  localparam logic [PW-1:0] PosMax = {PW{1'b1}};

  stbs_pkg::mode_e mode_q, mode_d;
  logic [PW-1:0]   origin_q, origin_d;
  logic [PW-1:0]   pos_q, pos_d;
  logic            saw_letter_q, saw_letter_d;
  logic            saw_point_q, saw_point_d;
  logic            ovf_q, ovf_d;

  logic [7:0]    c;
  logic          is_end;
  logic          at_max;
  logic          word_cont;
  logic          dot_ok;
  logic          do_flush;
  logic          do_begin;
  logic          do_pair;
  logic          ovf_now;
  logic [PW-1:0] dot_pos;
  logic [1:0]    n;
  stbs_pkg::out_item_t res [stbs_pkg::MaxResults];

  function automatic logic [15:0] sat16(input logic [PW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic stbs_pkg::out_item_t mk(input logic [3:0] kind,
                                              input logic [PW-1:0] start,
                                              input logic [PW-1:0] len,
                                              input logic ovf);
    stbs_pkg::out_item_t r;
    r.token_kind    = kind;
    r.token_start   = sat16(start);
    r.token_length  = sat16(len);
    r.overflow_seen = ovf;
    r.run_last      = 1'b0;
    return r;
  endfunction

  function automatic logic [PW-1:0] span(input logic [PW-1:0] from,
                                         input logic [PW-1:0] to);
    return (to > from) ? (to - from) : '0;
  endfunction

  assign c         = in_item_i.byte_value;
  assign is_end    = in_item_i.end_mark;
  assign at_max    = (pos_q == PosMax);
  assign word_cont = stbs_pkg::is_digit(c) || stbs_pkg::is_alpha(c) || (c == stbs_pkg::CH_UNDER);
  assign dot_ok    = (c == stbs_pkg::CH_DOT) && !saw_letter_q && !saw_point_q;
  assign ovf_now   = is_end ? ovf_q : (ovf_q | at_max);
  assign dot_pos   = (pos_q != '0) ? (pos_q - PW'(1)) : '0;

  // What this byte does to the open token.
  always_comb begin
    do_flush = 1'b0;
    do_begin = 1'b0;
    do_pair  = 1'b0;
    if (is_end) begin
      do_flush = 1'b1;
    end else begin
      case (mode_q)
        stbs_pkg::MODE_WORD: begin
          if (!word_cont && !dot_ok) begin
            do_flush = 1'b1;
            do_begin = 1'b1;
          end
        end
        stbs_pkg::MODE_MINUS, stbs_pkg::MODE_DOT: begin
          if (!stbs_pkg::is_digit(c)) begin
            do_flush = 1'b1;
            do_begin = 1'b1;
          end
        end
        stbs_pkg::MODE_STRING: begin
          do_flush = (c == stbs_pkg::CH_QUOTE);
        end
        stbs_pkg::MODE_GT, stbs_pkg::MODE_LT: begin
          if (c == stbs_pkg::CH_EQUALS) begin
            do_pair = 1'b1;
          end else begin
            do_flush = 1'b1;
            do_begin = 1'b1;
          end
        end
        default: begin
          do_begin = 1'b1;
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    mode_d       = mode_q;
    origin_d     = origin_q;
    pos_d        = pos_q;
    saw_letter_d = saw_letter_q;
    saw_point_d  = saw_point_q;
    ovf_d        = ovf_q;
    if (accept_i) begin
      if (is_end) begin
        mode_d       = stbs_pkg::MODE_IDLE;
        origin_d     = '0;
        pos_d        = '0;
        saw_letter_d = 1'b0;
        saw_point_d  = 1'b0;
        ovf_d        = 1'b0;
      end else begin
        pos_d = at_max ? PosMax : (pos_q + PW'(1));
        ovf_d = ovf_q | at_max;
        case (mode_q)
          stbs_pkg::MODE_WORD: begin
            if (word_cont) begin
              if (stbs_pkg::is_alpha(c)) saw_letter_d = 1'b1;
            end else if (dot_ok) begin
              mode_d = stbs_pkg::MODE_DOT;
            end
          end
          stbs_pkg::MODE_MINUS: begin
            if (stbs_pkg::is_digit(c)) begin
              mode_d       = stbs_pkg::MODE_WORD;
              saw_letter_d = 1'b0;
              saw_point_d  = 1'b0;
            end
          end
          stbs_pkg::MODE_DOT: begin
            if (stbs_pkg::is_digit(c)) begin
              mode_d      = stbs_pkg::MODE_WORD;
              saw_point_d = 1'b1;
            end
          end
          default: ;
        endcase
        if (do_flush || do_pair) mode_d = stbs_pkg::MODE_IDLE;
        if (do_begin) begin
          mode_d = stbs_pkg::MODE_IDLE;
          if (stbs_pkg::is_digit(c) || stbs_pkg::is_alpha(c)) begin
            mode_d       = stbs_pkg::MODE_WORD;
            origin_d     = pos_q;
            saw_letter_d = stbs_pkg::is_alpha(c);
            saw_point_d  = 1'b0;
          end else begin
            case (c)
              stbs_pkg::CH_MINUS: begin
                mode_d   = stbs_pkg::MODE_MINUS;
                origin_d = pos_q;
              end
              stbs_pkg::CH_QUOTE: begin
                mode_d   = stbs_pkg::MODE_STRING;
                // string text starts after the quote
                origin_d = at_max ? pos_q : (pos_q + PW'(1));
              end
              stbs_pkg::CH_GT: begin
                mode_d   = stbs_pkg::MODE_GT;
                origin_d = pos_q;
              end
              stbs_pkg::CH_LT: begin
                mode_d   = stbs_pkg::MODE_LT;
                origin_d = pos_q;
              end
              default: ;
            endcase
          end
        end
      end
    end
  end

  // Token emission
  always_comb begin
    n = 2'd0;
    for (int i = 0; i < stbs_pkg::MaxResults; i++) res[i] = '0;

    if (do_flush) begin
      case (mode_q)
        stbs_pkg::MODE_WORD: begin
          res[n] = mk(saw_letter_q ? stbs_pkg::KIND_WORD :
                      (saw_point_q ? stbs_pkg::KIND_DECIMAL : stbs_pkg::KIND_INTEGER),
                      origin_q, span(origin_q, pos_q), ovf_now);
          n = n + 2'd1;
        end
        stbs_pkg::MODE_MINUS: begin
          res[n] = mk(stbs_pkg::KIND_INVALID, origin_q, PW'(1), ovf_now);
          n = n + 2'd1;
        end
        stbs_pkg::MODE_DOT: begin
          // number before the dot, then the dangling dot
          res[n] = mk(saw_letter_q ? stbs_pkg::KIND_WORD :
                      (saw_point_q ? stbs_pkg::KIND_DECIMAL : stbs_pkg::KIND_INTEGER),
                      origin_q, span(origin_q, dot_pos), ovf_now);
          n = n + 2'd1;
          res[n] = mk(stbs_pkg::KIND_INVALID, dot_pos, PW'(1), ovf_now);
          n = n + 2'd1;
        end
        stbs_pkg::MODE_STRING: begin
          res[n] = mk(stbs_pkg::KIND_STRING, origin_q, span(origin_q, pos_q), ovf_now);
          n = n + 2'd1;
        end
        stbs_pkg::MODE_GT: begin
          res[n] = mk(stbs_pkg::KIND_GT, origin_q, PW'(1), ovf_now);
          n = n + 2'd1;
        end
        stbs_pkg::MODE_LT: begin
          res[n] = mk(stbs_pkg::KIND_LT, origin_q, PW'(1), ovf_now);
          n = n + 2'd1;
        end
        default: ;
      endcase
    end

    if (do_pair) begin
      res[n] = mk((mode_q == stbs_pkg::MODE_GT) ? stbs_pkg::KIND_GE : stbs_pkg::KIND_LE,
                  origin_q, PW'(2), ovf_now);
      n = n + 2'd1;
    end

    if (do_begin && !stbs_pkg::is_space(c) && !stbs_pkg::is_digit(c) &&
        !stbs_pkg::is_alpha(c)) begin
      case (c)
        stbs_pkg::CH_MINUS, stbs_pkg::CH_QUOTE, stbs_pkg::CH_GT, stbs_pkg::CH_LT: ;
        stbs_pkg::CH_STAR: begin
          res[n] = mk(stbs_pkg::KIND_STAR, pos_q, PW'(1), ovf_now);
          n = n + 2'd1;
        end
        stbs_pkg::CH_COMMA: begin
          res[n] = mk(stbs_pkg::KIND_COMMA, pos_q, PW'(1), ovf_now);
          n = n + 2'd1;
        end
        stbs_pkg::CH_LPAREN: begin
          res[n] = mk(stbs_pkg::KIND_LPAREN, pos_q, PW'(1), ovf_now);
          n = n + 2'd1;
        end
        stbs_pkg::CH_RPAREN: begin
          res[n] = mk(stbs_pkg::KIND_RPAREN, pos_q, PW'(1), ovf_now);
          n = n + 2'd1;
        end
        stbs_pkg::CH_SEMI: begin
          res[n] = mk(stbs_pkg::KIND_SEMICOLON, pos_q, PW'(1), ovf_now);
          n = n + 2'd1;
        end
        stbs_pkg::CH_EQUALS: begin
          res[n] = mk(stbs_pkg::KIND_EQUALS, pos_q, PW'(1), ovf_now);
          n = n + 2'd1;
        end
        default: begin
          res[n] = mk(stbs_pkg::KIND_INVALID, pos_q, PW'(1), ovf_now);
          n = n + 2'd1;
        end
      endcase
    end

    if (is_end) begin
      res[n] = mk(stbs_pkg::KIND_END, pos_q, '0, ovf_now);
      n = n + 2'd1;
    end

    if (n != 2'd0) res[n - 2'd1].run_last = 1'b1;
  end

  always_comb begin
    grp_o.count = n;
    for (int i = 0; i < stbs_pkg::MaxResults; i++) grp_o.item[i] = res[i];
  end
  assign grp_valid_o = accept_i && (n != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= stbs_pkg::MODE_IDLE;
      origin_q     <= '0;
      pos_q        <= '0;
      saw_letter_q <= 1'b0;
      saw_point_q  <= 1'b0;
      ovf_q        <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      origin_q     <= origin_d;
      pos_q        <= pos_d;
      saw_letter_q <= saw_letter_d;
      saw_point_q  <= saw_point_d;
      ovf_q        <= ovf_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/stbs_group_fifo.sv */
// Two-entry queue of token groups between scanner front and output stage.
// Depends on stbs_pkg.
`default_nettype none

module stbs_group_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire stbs_pkg::group_t wdata_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output stbs_pkg::group_t      rdata_o
);

  localparam int unsigned Depth = 2;

  stbs_pkg::group_t mem_q [Depth];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'(Depth));
  assign valid_o = (cnt_q != 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

/* rtl/core/stbs_back.sv */
// Output stage: holds one token group and hands its tokens out one per pop.
// Depends on stbs_pkg.
`default_nettype none

module stbs_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             grp_valid_i,
  input  wire stbs_pkg::group_t grp_i,
  output logic                  grp_take_o,
  output logic                  empty_o,
  input  wire logic             pop_i,
  output stbs_pkg::out_item_t   out_item_o
);

  stbs_pkg::group_t cur_q;
  logic [1:0]       idx_q;
  logic             valid_q;
  logic             take, last, load;

  assign last       = (idx_q == (cur_q.count - 2'd1));
  assign take       = pop_i && valid_q;
  // refill when empty, or on the same edge the last token of the group leaves
  assign load       = grp_valid_i && (!valid_q || (take && last));
  assign grp_take_o = load;
  assign empty_o    = !valid_q;
  assign out_item_o = cur_q.item[idx_q];

  always_ff @(posedge clk_i) begin
    if (load) cur_q <= grp_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= 2'd0;
    end else if (take) begin
      if (last) valid_q <= 1'b0;
      else      idx_q   <= idx_q + 2'd1;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/stbs_checker.sv */
// Port-level checks for the SQL token boundary scanner, bound to the top level.
// Depends on stbs_pkg.
`default_nettype none

module stbs_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                empty,
  input wire logic                pop,
  input wire stbs_pkg::out_item_t out_item_o
);

  // a waiting result holds until popped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("result changed while stalled");

  // rest of a token group is already in the output stage
  a_group_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !out_item_o.run_last) |=> !empty)
    else $error("gap inside a token group");

  // end token closes its group and has no text
  a_end_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (out_item_o.token_kind == stbs_pkg::KIND_END)) |->
      (out_item_o.run_last && (out_item_o.token_length == 16'd0)))
    else $error("malformed end token");

  // nothing to deliver while held in reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> empty)
    else $error("result shown during reset");

endmodule

bind sql_token_boundary_scanner stbs_checker u_stbs_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .empty     (empty),
  .pop       (pop),
  .out_item_o(out_item_o)
);

`default_nettype wire
